@@ rtl/core/gedf_pkg.sv @@
// Shared types and constants for the global EDF response-time test core.
package gedf_pkg;

   // Request commands.
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_RUN    = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_CORE_COUNT = 1'b0;
   localparam logic CSR_ITER_LIMIT = 1'b1;

   localparam logic [6:0]  CORE_COUNT_RESET = 7'd1;
   localparam logic [15:0] ITER_LIMIT_RESET = 16'd1024;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] period;
      logic [15:0] deadline;
      logic [15:0] exec_time;
   } req_type;

   typedef struct packed {
      logic        schedulable;
      logic        gave_up;
      logic [15:0] rounds_used;
   } rsp_type;

   // Start and finish handshake of the divider.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

@@ rtl/core/gedf_div.sv @@
// Sequential floor divider: signed 50-bit dividend by unsigned 16-bit divisor.
module gedf_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [49:0] dividend,
   input  logic [15:0]        divisor,
   output gedf_pkg::div_ctl_type ctl,
   output logic signed [49:0] quotient,
   output logic signed [49:0] remainder
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  count_ff, count_in;
   logic [49:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] trial;
   logic [49:0] mag;
   logic [49:0] qfix;
   logic [16:0] rfix;

   assign mag = dividend[49] ? 50'(-dividend) : 50'(dividend);
   assign trial = {rem_ff[15:0], quo_ff[49]};

   // Restoring division, one quotient bit a cycle.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 6'd0;
         quo_in   = mag;
         rem_in   = 17'd0;
         neg_in   = dividend[49];
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[48:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[48:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd49) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      dsr_ff   <= dsr_in;
   end

   // Floor correction for a negative dividend.
   always_comb begin
      qfix = quo_ff;
      rfix = rem_ff;
      if (neg_ff) begin
         if (rem_ff != 17'd0) begin
            qfix = 50'(-quo_ff) - 50'd1;
            rfix = {1'b0, dsr_ff} - rem_ff;
         end else begin
            qfix = 50'(-quo_ff);
         end
      end
   end

   assign quotient  = qfix;
   assign remainder = 50'(rfix);
   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;

endmodule

@@ rtl/core/global_edf_response_time_test_core.sv @@
// Top level of the global EDF response-time test core.
//
//  Channel | Ports           | Moves
//  --------+-----------------+---------------------------------------
//  req     | req_valid/ready | one request: load, run or clear
//  rsp     | rsp_valid/ready | one result for each run request
//  csr     | csr_write_en    | core count and round limit writes
//
// Load and clear are handled in the idle state. In a run round each task pair needs
// two 50-step divisions in the shared divider and each task one more by the core count;
// the divider sets the rate. Reset empties the task set; memories need no
// clearing. A stalled result holds in the output register while the core waits idle.
module global_edf_response_time_test_core #(
   parameter int MAX_TASKS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gedf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gedf_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [15:0]       csr_write_data
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_SLK  = 5'd1;
   localparam logic [4:0] S_SLK2 = 5'd2;
   localparam logic [4:0] S_KRD  = 5'd3;
   localparam logic [4:0] S_KLAT = 5'd4;
   localparam logic [4:0] S_IRD  = 5'd5;
   localparam logic [4:0] S_ILAT = 5'd6;
   localparam logic [4:0] S_WX   = 5'd7;
   localparam logic [4:0] S_WDIV = 5'd8;
   localparam logic [4:0] S_WMUL = 5'd9;
   localparam logic [4:0] S_QDIV = 5'd10;
   localparam logic [4:0] S_QWT  = 5'd11;
   localparam logic [4:0] S_QMUL = 5'd12;
   localparam logic [4:0] S_ACC  = 5'd13;
   localparam logic [4:0] S_MDIV = 5'd14;
   localparam logic [4:0] S_MWT  = 5'd15;
   localparam logic [4:0] S_UPD  = 5'd16;
   localparam logic [4:0] S_ULAT = 5'd17;
   localparam logic [4:0] S_UCMP = 5'd18;
   localparam logic [4:0] S_DONE = 5'd19;
   localparam logic [4:0] S_OUT  = 5'd20;

   localparam logic signed [49:0] SMAX = 50'sd2147483647;
   localparam logic signed [49:0] SMIN = -50'sd2147483648;
   localparam logic signed [49:0] SUM_FLOOR = -50'sd140737488355328;

   // Task memories.
   logic [15:0]        per_mem [MAX_TASKS];
   logic [15:0]        dl_mem  [MAX_TASKS];
   logic [15:0]        ex_mem  [MAX_TASKS];
   logic signed [31:0] rb_mem  [MAX_TASKS];
   logic signed [31:0] sl_mem  [MAX_TASKS];
   logic signed [31:0] bn_mem  [MAX_TASKS];

   logic [4:0]   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] k_ff, k_in, i_ff, i_in, addr;
   logic [6:0]   cores_ff;
   logic [15:0]  limit_ff, rounds_ff, rounds_in;
   logic         met_ff, met_in, chg_ff, chg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   gedf_pkg::rsp_type rsp_ff, rsp_in;

   // Registered memory read data.
   logic [15:0]        per_q, dl_q, ex_q;
   logic signed [31:0] rb_q, sl_q, bn_q;

   // Work registers for the current task pair.
   logic signed [31:0] rbk_ff, rbk_in;
   logic [15:0]        dlk_ff, dlk_in, exk_ff, exk_in;
   logic signed [49:0] sum_ff, sum_in, x_ff, x_in, w_ff, w_in, v_ff, v_in;

   // Memory write controls.
   logic                wr_task, wr_sl, wr_bn, wr_rb;
   logic signed [31:0]  wdata_sl, wdata_bn, wdata_rb;

   // Divider.
   logic                 dstart;
   logic signed [49:0]   ddend, dquo, drem;
   logic [15:0]          dsor;
   gedf_pkg::div_ctl_type dctl;

   gedf_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(ddend),
      .divisor(dsor), .ctl(dctl), .quotient(dquo), .remainder(drem)
   );

   logic signed [49:0] slk_full, cap, mc, wmul, qmul, rq, rterm, minv, bnew;
   logic [6:0]         cores_eff;
   logic               accepted;

   assign accepted  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cores_eff = (cores_ff == 7'd0) ? 7'd1 : cores_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cores_ff <= gedf_pkg::CORE_COUNT_RESET;
         limit_ff <= gedf_pkg::ITER_LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            gedf_pkg::CSR_CORE_COUNT: cores_ff <= csr_write_data[6:0];
            gedf_pkg::CSR_ITER_LIMIT: limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Memory address selection.
   always_comb begin
      case (state_ff)
         S_KRD, S_MWT, S_UPD, S_ULAT, S_UCMP: addr = k_ff;
         S_IDLE:       addr = count_ff[IW-1:0];
         default:      addr = i_ff;
      endcase
   end

   // Memories: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_task) begin
         per_mem[addr] <= req_data.period;
         dl_mem[addr]  <= req_data.deadline;
         ex_mem[addr]  <= req_data.exec_time;
      end
      if (wr_rb) rb_mem[addr] <= wdata_rb;
      if (wr_sl) sl_mem[addr] <= wdata_sl;
      if (wr_bn) bn_mem[addr] <= wdata_bn;
      per_q <= per_mem[addr];
      dl_q  <= dl_mem[addr];
      ex_q  <= ex_mem[addr];
      rb_q  <= rb_mem[addr];
      sl_q  <= sl_mem[addr];
      bn_q  <= bn_mem[addr];
   end

   // Datapath helpers.
   always_comb begin
      slk_full = 50'(signed'({1'b0, dl_q})) - 50'(rb_q);
      cap   = 50'(rbk_ff) - 50'(signed'({1'b0, exk_ff})) + 50'sd1;
      mc    = 50'(signed'({1'b0, ex_q}));
      wmul  = dquo * mc;
      qmul  = dquo * mc;
      rq    = drem - 50'(sl_q);
      rterm = (rq < 50'sd0) ? 50'sd0 : rq;
      minv  = (w_ff < v_ff) ? w_ff : v_ff;
      minv  = (minv < cap) ? minv : cap;
      bnew  = 50'(signed'({1'b0, exk_ff})) + dquo;
      bnew  = (bnew > SMAX) ? SMAX : ((bnew < SMIN) ? SMIN : bnew);
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff; count_in = count_ff; k_in = k_ff; i_in = i_ff;
      rounds_in = rounds_ff; met_in = met_ff; chg_in = chg_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      rbk_in = rbk_ff; dlk_in = dlk_ff; exk_in = exk_ff;
      sum_in = sum_ff; x_in = x_ff; w_in = w_ff; v_in = v_ff;
      wr_task = 1'b0; wr_sl = 1'b0; wr_bn = 1'b0; wr_rb = 1'b0;
      wdata_sl = 32'sd0; wdata_bn = 32'(bnew); wdata_rb = bn_q;
      dstart = 1'b0; ddend = x_ff; dsor = per_q;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accepted) begin
               case (req_data.command)
                  gedf_pkg::CMD_LOAD: begin
                     if (req_data.period != 16'd0 && count_ff < CW'(MAX_TASKS)) begin
                        wr_task = 1'b1; wr_rb = 1'b1; wr_sl = 1'b1;
                        wdata_rb = 32'(signed'({1'b0, req_data.deadline}));
                        count_in = count_ff + CW'(1);
                     end
                  end
                  gedf_pkg::CMD_CLEAR: count_in = '0;
                  gedf_pkg::CMD_RUN: begin
                     rounds_in = 16'd0;
                     if (count_ff == '0) begin
                        rsp_in = '{schedulable: 1'b1, gave_up: 1'b0, rounds_used: 16'd0};
                        state_in = S_OUT;
                     end else begin
                        state_in = S_DONE;
                        met_in = 1'b0; chg_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // Slack pass over all tasks.
         S_SLK: state_in = S_SLK2;
         S_SLK2: begin
            wr_sl = 1'b1;
            wdata_sl = 32'((slk_full > SMAX) ? SMAX : ((slk_full < SMIN) ? SMIN : slk_full));
            if (32'(i_ff) + 32'd1 == 32'(count_ff)) begin
               k_in = '0; state_in = S_KRD;
            end else begin
               i_in = i_ff + IW'(1); state_in = S_SLK;
            end
         end
         S_KRD: state_in = S_KLAT;
         S_KLAT: begin
            rbk_in = rb_q; dlk_in = dl_q; exk_in = ex_q; sum_in = 50'sd0;
            i_in = '0; state_in = S_IRD;
         end
         S_IRD: begin
            if (i_ff == k_ff) state_in = S_ACC;
            else state_in = S_ILAT;
         end
         S_ILAT: begin
            x_in = 50'(rbk_ff) + 50'(signed'({1'b0, dl_q})) - 50'(signed'({1'b0, ex_q}))
                   - 50'(sl_q);
            state_in = S_WX;
         end
         S_WX: begin
            dstart = 1'b1; ddend = x_ff; state_in = S_WDIV;
         end
         S_WDIV: if (dctl.done) state_in = S_WMUL;
         S_WMUL: begin
            w_in = wmul + ((mc < drem) ? mc : drem);
            dstart = 1'b1; ddend = 50'(signed'({1'b0, dlk_ff})); state_in = S_QDIV;
         end
         S_QDIV: state_in = S_QWT;
         S_QWT: if (dctl.done) state_in = S_QMUL;
         S_QMUL: begin
            v_in = qmul + ((mc < rterm) ? mc : rterm);
            state_in = S_ACC;
         end
         S_ACC: begin
            if (i_ff != k_ff) begin
               sum_in = sum_ff + minv;
               // A sum below the floor saturates the new bound either way.
               if (sum_in < SUM_FLOOR) sum_in = SUM_FLOOR;
            end
            if (32'(i_ff) + 32'd1 == 32'(count_ff)) begin
               state_in = S_MDIV;
            end else begin
               i_in = i_ff + IW'(1); state_in = S_IRD;
            end
         end
         S_MDIV: begin
            dstart = 1'b1; ddend = sum_ff; dsor = 16'(cores_eff); state_in = S_MWT;
         end
         S_MWT: begin
            dsor = 16'(cores_eff);
            if (dctl.done) begin
               wr_bn = 1'b1; i_in = k_ff;
               if (32'(k_ff) + 32'd1 == 32'(count_ff)) begin
                  k_in = '0; met_in = 1'b1; chg_in = 1'b0; state_in = S_UPD;
               end else begin
                  k_in = k_ff + IW'(1); state_in = S_KRD;
               end
            end
         end
         // Bound update pass.
         S_UPD: state_in = S_ULAT;
         S_ULAT: state_in = S_UCMP;
         S_UCMP: begin
            i_in = k_ff;
            wr_rb = 1'b1; wdata_rb = bn_q;
            if (bn_q != rb_q) chg_in = 1'b1;
            if (bn_q > 32'(signed'({1'b0, dl_q}))) met_in = 1'b0;
            if (32'(k_ff) + 32'd1 == 32'(count_ff)) begin
               rounds_in = rounds_ff + 16'd1; state_in = S_DONE;
            end else begin
               k_in = k_ff + IW'(1); state_in = S_UPD;
            end
         end
         S_DONE: begin
            if (met_ff && rounds_ff != 16'd0) begin
               rsp_in = '{schedulable: 1'b1, gave_up: 1'b0, rounds_used: rounds_ff};
               state_in = S_OUT;
            end else if (!chg_ff) begin
               rsp_in = '{schedulable: 1'b0, gave_up: 1'b0, rounds_used: rounds_ff};
               state_in = S_OUT;
            end else if (rounds_ff >= limit_ff) begin
               rsp_in = '{schedulable: 1'b0, gave_up: 1'b1, rounds_used: rounds_ff};
               state_in = S_OUT;
            end else begin
               i_in = '0; state_in = S_SLK;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The update pass writes bound k with the address of k.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff <= k_in; i_ff <= i_in; rounds_ff <= rounds_in;
      met_ff <= met_in; chg_ff <= chg_in; rsp_ff <= rsp_in;
      rbk_ff <= rbk_in; dlk_ff <= dlk_in; exk_ff <= exk_in;
      sum_ff <= sum_in; x_ff <= x_in; w_ff <= w_in; v_ff <= v_in;
   end

   // Checks.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS)) else $error("task count overflow");

endmodule
